// ===== src/box_downsample_2x2_macros.svh =====
// Assertion macros for the box_downsample_2x2 checker.
// No dependencies; included by files that carry assertions.
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// same-cycle implication, disabled while dis is high
`define BDS_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while dis is high
`define BDS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bds2x2_pkg.sv =====
// Shared constants and types for the 2x2 box downsampler.
// No dependencies.
package bds2x2_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);

    localparam int SAMPLE_W   = 8;
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int OUT_COL_W  = 11;
    localparam int OUT_ROW_W  = 15;
    localparam int ROW_W      = 16;

    localparam int CFG_WIDTH_W  = 13;
    localparam int CFG_HEIGHT_W = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    // wide enough for the width register, the column count plus one and MAX_WIDTH
    localparam int EXT_W = (COL_W + 2 > CFG_WIDTH_W) ? COL_W + 2 : CFG_WIDTH_W;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(4096);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(4096);

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  avg;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_result;

endpackage

// ===== src/bds2x2_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bds2x2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/box_downsample_2x2.sv =====
// 2x2 box-filter downsampler, top level.
// Depends on bds2x2_pkg and bds2x2_ram.
//
// Accepts one 8-bit height sample per clock in row-major order, sustained
// while o_stall is low, and emits, for each complete 2x2 block, the
// truncated mean of its four samples with its half-size column and row
// and a frame-last flag. The completing sample (the odd-row, odd-column
// one) has its result registered in the result register, or in the one-word
// skid stage if that holds a stalled word. o_stall goes high only once
// both hold a word, i.e. after the downstream has stalled across two
// results. Even-row pair sums live in a 2048 x 9 line RAM with one write
// and one registered read port: a pair sum is written with the odd-column
// sample of an even row, and on an odd row the entry is read with the
// even-column sample so the data is ready when its partner arrives. A
// trailing odd column or row is absorbed without output. Writing either
// configuration register restarts the frame (counters and left-sample hold
// clear, line RAM kept); write only while the block is idle. Width acts as
// 2 when below 2 and as 4096 when above; height acts as 2 when below 2.
module box_downsample_2x2 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration, APB style
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bds2x2_pkg::PADDR_W-1:0]       paddr,
    input  logic [bds2x2_pkg::PDATA_W-1:0]       pwdata,
    output logic [bds2x2_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready,
    // sample input
    input  logic                                 i_valid,
    input  logic [bds2x2_pkg::SAMPLE_W-1:0]      i_height_sample,
    output logic                                 o_stall,
    // result output
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [bds2x2_pkg::SAMPLE_W-1:0]      o_averaged_sample,
    output logic [bds2x2_pkg::OUT_COL_W-1:0]     o_out_column,
    output logic [bds2x2_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic                                 o_frame_last
);

    import bds2x2_pkg::*;

    // config registers
    logic [CFG_WIDTH_W-1:0]  r_image_width;
    logic [CFG_HEIGHT_W-1:0] r_image_height;

    // frame position and left sample of the current pair
    logic [COL_W-1:0]    r_col,  n_col;
    logic [ROW_W-1:0]    r_row,  n_row;
    logic [SAMPLE_W-1:0] r_left, n_left;

    // output register and skid stage
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic cfg_wr;
    logic accept;
    logic produce;
    logic out_free;

    logic [EXT_W-1:0]    w_ext, w_eff, w_even, c_inc;
    logic [ROW_W:0]      h_eff, h_even, r_inc;
    logic                col_wrap;
    logic [LINE_AW-1:0]  line_idx;
    logic [PAIR_W-1:0]   pair_sum;
    logic [PAIR_W-1:0]   line_rd_data;
    logic                line_wr_en, line_rd_en;
    logic [SUM_W-1:0]    total;
    t_result             new_res;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_IMAGE_HEIGHT) ? PDATA_W'(r_image_height)
                                                     : PDATA_W'(r_image_width);

    assign accept   = i_valid && !r_skid_valid;
    assign o_stall  = r_skid_valid;

    // effective frame size
    assign w_ext  = EXT_W'(r_image_width);
    always_comb begin
        if (w_ext < EXT_W'(2)) begin
            w_eff = EXT_W'(2);
        end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
            w_eff = EXT_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (r_image_height < CFG_HEIGHT_W'(2)) begin
            h_eff = (ROW_W + 1)'(2);
        end else begin
            h_eff = (ROW_W + 1)'(r_image_height);
        end
    end
    assign w_even   = {w_eff[EXT_W-1:1], 1'b0};
    assign h_even   = {h_eff[ROW_W:1], 1'b0};
    assign c_inc    = EXT_W'(r_col) + EXT_W'(1);
    assign r_inc    = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(1);
    assign col_wrap = (c_inc >= w_eff);

    // line RAM access: write on even rows, prefetch on odd rows
    assign line_idx   = LINE_AW'(r_col >> 1);
    assign pair_sum   = PAIR_W'(r_left) + PAIR_W'(i_height_sample);
    assign line_wr_en = accept && r_col[0] && !r_row[0];
    assign line_rd_en = accept && !r_col[0] && r_row[0];

    bds2x2_ram #(
        .WIDTH(PAIR_W),
        .DEPTH(LINE_DEPTH)
    ) u_line (
        .i_clk    (i_clk),
        .i_wr_en  (line_wr_en),
        .i_wr_addr(line_idx),
        .i_wr_data(pair_sum),
        .i_rd_en  (line_rd_en),
        .i_rd_addr(line_idx),
        .o_rd_data(line_rd_data)
    );

    // block result
    assign produce      = accept && r_col[0] && r_row[0];
    assign total        = SUM_W'(line_rd_data) + SUM_W'(r_left) + SUM_W'(i_height_sample);
    assign new_res.avg  = total[SUM_W-1:2];
    assign new_res.col  = OUT_COL_W'(line_idx);
    assign new_res.row  = OUT_ROW_W'(r_row >> 1);
    assign new_res.last = (c_inc == w_even) && (r_inc == h_even);

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_left       = r_left;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;

        if (cfg_wr) begin
            // any config write restarts the frame
            n_col  = '0;
            n_row  = '0;
            n_left = '0;
        end else if (accept) begin
            if (!r_col[0]) begin
                n_left = i_height_sample;
            end
            if (col_wrap) begin
                n_col = '0;
                n_row = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
            end else begin
                n_col = c_inc[COL_W-1:0];
            end
        end

        if (out_free) begin
            if (r_skid_valid) begin
                // no accept this cycle, skid drains
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (produce) begin
                n_out       = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (produce) begin
            n_skid       = new_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_left         <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_IMAGE_WIDTH) begin
                    r_image_width <= pwdata[CFG_WIDTH_W-1:0];
                end else begin
                    r_image_height <= pwdata[CFG_HEIGHT_W-1:0];
                end
            end
            r_col        <= n_col;
            r_row        <= n_row;
            r_left       <= n_left;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        // payload, no reset
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid           = r_out_valid;
    assign o_averaged_sample = r_out.avg;
    assign o_out_column      = r_out.col;
    assign o_out_row         = r_out.row;
    assign o_frame_last      = r_out.last;

endmodule

// ===== src/bds2x2_checker.sv =====
// Port-level checker for box_downsample_2x2, bound to the top level.
// Depends on bds2x2_pkg and box_downsample_2x2_macros.svh.
`include "box_downsample_2x2_macros.svh"

module bds2x2_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [bds2x2_pkg::SAMPLE_W-1:0]  o_averaged_sample,
    input logic [bds2x2_pkg::OUT_COL_W-1:0] o_out_column,
    input logic [bds2x2_pkg::OUT_ROW_W-1:0] o_out_row,
    input logic                             o_frame_last
);

    // reset empties result register and skid
    `BDS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid && !o_stall, "not empty after reset")

    // stalled result word holds
    `BDS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall, o_valid && $stable(o_averaged_sample) && $stable(o_out_column) && $stable(o_out_row) && $stable(o_frame_last), "stalled result changed")

    // a new result follows an accepted sample
    `BDS_ASSERT_NOW(a_rose_valid, i_clk, !i_rst_n, $rose(o_valid), $past(i_valid && !o_stall), "result without input word")

    // input stall only after a stalled result word
    `BDS_ASSERT_NOW(a_rose_stall, i_clk, !i_rst_n, $rose(o_stall), $past(o_valid && i_stall), "stall without output backpressure")

endmodule

bind box_downsample_2x2 bds2x2_checker u_bds2x2_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for box_downsample_2x2.
// Needs bds2x2_pkg and the block's RTL. It predicts every block mean from its
// own line-buffer model and checks each result word as it leaves the block.
module tb_top;
    import bds2x2_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 200_000;
    localparam int TAIL_CYCLES = 16;
    localparam int SETTLE_CYCLES = 4;    // each result leaves from a register, not combinationally
    localparam int RANDOM_PER_PHASE = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   i_valid = 1'b0;
    logic [SAMPLE_W-1:0]    i_height_sample = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [SAMPLE_W-1:0]    o_averaged_sample;
    logic [OUT_COL_W-1:0]   o_out_column;
    logic [OUT_ROW_W-1:0]   o_out_row;
    logic                   o_frame_last;

    box_downsample_2x2 u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .i_height_sample   (i_height_sample),
        .o_stall           (o_stall),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_averaged_sample (o_averaged_sample),
        .o_out_column      (o_out_column),
        .o_out_row         (o_out_row),
        .o_frame_last      (o_frame_last)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the block: config registers, scan position, left sample
    // of the open pair and the even-row pair sums, one per output column.
    // ------------------------------------------------------------------
    logic [CFG_WIDTH_W-1:0]  cfg_width = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
    int unsigned             col_pos = 0;
    int unsigned             row_pos = 0;
    logic [SAMPLE_W-1:0]     left_px = '0;
    logic [PAIR_W-1:0]       pair_sums [0:LINE_DEPTH-1];

    t_result means_due [$];   // block means predicted but not yet seen

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // bookkeeping
    int errors = 0;
    int n_samples = 0;
    int n_means = 0;
    int n_frame_ends = 0;
    int n_writes = 0;
    int cycle_count = 0;

    // Advance the shadow by one accepted sample. A mean is due when the
    // odd-column sample of an odd row closes a 2x2 block.
    function automatic void box_mean_step(input logic [SAMPLE_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        logic [PAIR_W-1:0] pair;
        logic [SUM_W-1:0]  total;
        t_result          m;
        // width clamps to 2..MAX_WIDTH, height only from below
        w = (cfg_width < 2) ? 2 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h = (cfg_height < 2) ? 2 : cfg_height;
        if (col_pos[0] == 1'b0) begin
            left_px = px;
        end else begin
            pair = {1'b0, left_px} + {1'b0, px};
            idx = col_pos >> 1;
            if (row_pos[0] == 1'b0) begin
                pair_sums[idx] = pair;
            end else begin
                total = {1'b0, pair_sums[idx]} + {1'b0, pair};
                m.avg  = total[SUM_W-1:2];
                m.col  = idx[OUT_COL_W-1:0];
                m.row  = row_pos[OUT_ROW_W:1];
                m.last = (col_pos == (w & ~32'd1) - 1) && (row_pos == (h & ~32'd1) - 1);
                means_due.insert(means_due.size(), m);
            end
        end
        // trailing odd column/row simply falls through without a mean
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        n_samples++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return SAMPLE_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Sample word: drive at the falling edge, maybe idle first, then hold
    // until a rising edge with o_stall low takes it.
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [SAMPLE_W-1:0] px);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_height_sample <= SAMPLE_W'($urandom_range(255));
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_height_sample <= px;
        do @(posedge i_clk); while (o_stall);
        box_mean_step(px);
    endtask

    // Drop valid and hold off until every predicted mean has come out, then
    // wait out SETTLE_CYCLES so a trailing sample with no mean is through too.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (means_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write (setup + access), then read it back. Only called when idle.
    task automatic cfg_write(input logic idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] got;
        hold_until_drained();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        // register taken at the edge just passed; any write restarts the frame
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = data[CFG_WIDTH_W-1:0];
            want = PDATA_W'(cfg_width);
        end else begin
            cfg_height = data[CFG_HEIGHT_W-1:0];
            want = PDATA_W'(cfg_height);
        end
        col_pos = 0;
        row_pos = 0;
        left_px = '0;
        n_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $display("%0t readback reg %0d: expected %0h, got %0h", $time, idx, want, got);
            errors++;
        end
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic set_idling(input int s, input int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall at the falling edge; result words are
    // checked at the rising edge against the oldest predicted mean.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    t_result got_mean;
    t_result want_mean;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_mean = '{o_averaged_sample, o_out_column, o_out_row, o_frame_last};
            if (means_due.size() == 0) begin
                $display("%0t unexpected word: avg %0d col %0d row %0d last %0b", $time,
                         got_mean.avg, got_mean.col, got_mean.row, got_mean.last);
                errors++;
            end else begin
                want_mean = means_due.pop_front();
                if (got_mean.avg !== want_mean.avg || got_mean.col !== want_mean.col ||
                    got_mean.row !== want_mean.row || got_mean.last !== want_mean.last) begin
                    $display("%0t mismatch (avg col row last): expected %0d %0d %0d %0b, %s",
                             $time, want_mean.avg, want_mean.col, want_mean.row,
                             want_mean.last,
                             $sformatf("got %0d %0d %0d %0b", got_mean.avg, got_mean.col,
                                       got_mean.row, got_mean.last));
                    errors++;
                end
                n_means++;
                if (want_mean.last) n_frame_ends++;
            end
        end
    end

    // watchdog: also catches means that never arrive
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d means outstanding",
                     cycle_count, means_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 4096 wide, so a short burst stays on row 0 and must
    // give no mean at all.
    task automatic test_reset_defaults();
        set_idling(0, 0);
        repeat (16) push_sample(rand_sample());
    endtask

    // Sample extremes, truncation, trailing odd column and row, and width
    // and height written below range.
    task automatic test_block_extremes();
        logic [SAMPLE_W-1:0] seq [$];
        set_idling(0, 0);
        set_frame(2, 2);
        repeat (4) push_sample(8'hFF);
        repeat (4) push_sample(8'h00);
        seq = '{8'd1, 8'd2, 8'd3, 8'd5};          // 11/4 truncates to 2
        foreach (seq[k]) push_sample(seq[k]);
        set_frame(3, 3);                          // only the top-left block counts
        seq = '{8'd10, 8'd20, 8'd255, 8'd30, 8'd40, 8'd255, 8'd255, 8'd255, 8'd255};
        foreach (seq[k]) push_sample(seq[k]);
        set_frame(1, 1);                          // both act as 2
        seq = '{8'd200, 8'd201, 8'd202, 8'd203};
        foreach (seq[k]) push_sample(seq[k]);
        set_frame(0, 0);
        seq = '{8'd254, 8'd255, 8'd255, 8'd255};
        foreach (seq[k]) push_sample(seq[k]);
    endtask

    // Width register at its top value acts as MAX_WIDTH: a short burst on
    // row 0 gives no mean, and the readback keeps all 13 bits.
    task automatic test_wide_frame();
        set_idling(0, 0);
        set_frame(32'h1FFF, 2);
        repeat (16) push_sample(rand_sample());
    endtask

    // Narrowest width with an odd height: every output row, the trailing
    // odd row, row wrap, then the start of the next frame.
    task automatic test_tall_frame();
        set_idling(0, 0);
        set_frame(2, 9);
        repeat (2 * 9 + 4) push_sample(rand_sample());
    endtask

    // Register write in the middle of a frame restarts it. The sender also
    // pauses here until all outstanding means are out.
    task automatic test_restart_mid_frame();
        set_idling(35, 35);
        set_frame(6, 4);
        repeat (9) push_sample(rand_sample());
        hold_until_drained();
        repeat (5) push_sample(rand_sample());
        cfg_write(REG_IMAGE_HEIGHT, 4);
        repeat (24) push_sample(rand_sample());
    endtask

    // Random small frames under each idling mix. Mostly whole frames;
    // about one in eight is cut short before the next register write.
    task automatic test_random_frames();
        int s_pct [4] = '{0, 85, 0, 35};
        int r_pct [4] = '{0, 0, 85, 35};
        int sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        bit held;
        for (int ph = 0; ph < 4; ph++) begin
            set_idling(s_pct[ph], r_pct[ph]);
            sent = 0;
            held = 1'b0;
            while (sent < RANDOM_PER_PHASE) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 11);
                h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 7);
                // junk in the upper bits must be ignored
                cfg_write(REG_IMAGE_WIDTH, {19'($urandom_range(32'h7FFFF)), 13'(w)});
                cfg_write(REG_IMAGE_HEIGHT, {16'($urandom_range(32'hFFFF)), 16'(h)});
                if (w < 2) w = 2;
                if (h < 2) h = 2;
                n = w * h;
                if ($urandom_range(7) == 0) begin
                    n = $urandom_range(1, n - 1);
                end else if ($urandom_range(3) == 0) begin
                    n = 2 * n;                    // run into the next frame
                end
                for (int unsigned k = 0; k < n; k++) begin
                    if (!held && k == n / 2) begin
                        hold_until_drained();
                        held = 1'b1;
                    end
                    push_sample(rand_sample());
                end
                sent += n;
            end
        end
    endtask

    initial begin
        for (int k = 0; k < LINE_DEPTH; k++) pair_sums[k] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_block_extremes();
        test_wide_frame();
        test_tall_frame();
        test_restart_mid_frame();
        test_random_frames();

        // wind down: no stall, wait for the last means, then a short tail
        @(negedge i_clk);
        i_valid <= 1'b0;
        set_idling(0, 0);
        while (means_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d samples in, %0d block means checked, %0d frame ends",
                 n_samples, n_means, n_frame_ends);
        $display("     %0d register writes, some with widths and heights out of range",
                 n_writes);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
